/* sv/assert_macros.svh */
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// implication checked on the following clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* sv/u8vbs_pkg.sv */
package u8vbs_pkg;

    // configuration register indexes
    localparam logic CFG_FATAL_MODE = 1'b0;
    localparam logic CFG_KEEP_BOM   = 1'b1;

    localparam logic [7:0] BYTE_EF   = 8'hEF;
    localparam logic [7:0] BYTE_BB   = 8'hBB;
    localparam logic [7:0] BYTE_BF   = 8'hBF;
    localparam logic [7:0] ASCII_LIM = 8'h80;
    localparam logic [7:0] LEAD_2B   = 8'hC2;
    localparam logic [7:0] LEAD_3B   = 8'hE0;
    localparam logic [7:0] LEAD_SURR = 8'hED;
    localparam logic [7:0] LEAD_4B   = 8'hF0;
    localparam logic [7:0] LEAD_MAX  = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_8F   = 8'h8F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_present;
        logic       run_last;
        logic       buffer_done;
        logic       invalid_text;
    } t_out;

    typedef enum logic [3:0] {
        BOM_START = 4'b0001,
        BOM_EF    = 4'b0010,
        BOM_EFBB  = 4'b0100,
        BOM_PAST  = 4'b1000
    } t_bom;

    // allowed range of the byte after a lead
    typedef enum logic [2:0] {
        RULE_ANY   = 3'd0,
        RULE_A0_BF = 3'd1,
        RULE_80_9F = 3'd2,
        RULE_90_BF = 3'd3,
        RULE_80_8F = 3'd4
    } t_rule;

    typedef struct packed {
        logic [1:0] cont_left;
        t_rule      rule;
        logic       err;
    } t_chk;

    function automatic t_chk check_byte(t_chk s, logic [7:0] b);
        t_chk r;
        logic ok;
        r  = s;
        ok = 1'b1;
        if (s.cont_left != 2'd0) begin
            ok = ((b & CONT_MASK) == CONT_TAG);
            unique case (s.rule)
                RULE_A0_BF: if (b < CONT_A0) ok = 1'b0;
                RULE_80_9F: if (b >= CONT_A0) ok = 1'b0;
                RULE_90_BF: if (b < CONT_90) ok = 1'b0;
                RULE_80_8F: if (b > CONT_8F) ok = 1'b0;
                default: ;
            endcase
            r.rule = RULE_ANY;
            if (ok) begin
                r.cont_left = s.cont_left - 2'd1;
            end else begin
                r.err       = 1'b1;
                r.cont_left = 2'd0;
            end
        end
        // a byte that breaks a sequence is retried as a lead
        if (s.cont_left == 2'd0 || !ok) begin
            priority if (b < ASCII_LIM) begin
            end else if (b < LEAD_2B) begin
                r.err = 1'b1;
            end else if (b < LEAD_3B) begin
                r.cont_left = 2'd1;
            end else if (b < LEAD_4B) begin
                r.cont_left = 2'd2;
                if (b == LEAD_3B) r.rule = RULE_A0_BF;
                else if (b == LEAD_SURR) r.rule = RULE_80_9F;
            end else if (b <= LEAD_MAX) begin
                r.cont_left = 2'd3;
                if (b == LEAD_4B) r.rule = RULE_90_BF;
                else if (b == LEAD_MAX) r.rule = RULE_80_8F;
            end else begin
                r.err = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

/* sv/utf8_validate_bom_strip.sv */
// utf-8 filter: validates the text and strips a leading bom unless keep_bom
//
// input channel: one byte of a buffer per word, last_byte set on the final
// byte. output channel: one result word per cycle unless stalled, up to three
// results per input byte (held bom bytes plus the current byte), run_last on
// the last of them, buffer_done and invalid_text on the buffer's final result
// config port: i_cfg_we writes fatal_mode (index 0) or keep_bom (index 1)
// an accepted byte waits in r_in, then its results go into the result queue
// throughput: one byte per cycle while the receiver is ready and each byte
// gives one result; a byte that releases held bom bytes gives two or three
// results, and the single read side of the four-entry queue then sets the pace
// reset clears the bom tracker, the checker state, both config registers
// and the queue. when the receiver stalls, the queue fills up to its depth,
// and ready goes low while a byte waits with two or more results queued
module utf8_validate_bom_strip (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  u8vbs_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output u8vbs_pkg::t_out  o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic             i_cfg_wdata
);
    import u8vbs_pkg::*;

    logic       r_fatal_mode;
    logic       r_keep_bom;
    logic       r_in_vld;
    t_in        r_in;
    t_bom       r_bom;
    t_bom       n_bom;
    t_chk       r_chk;
    t_chk       n_chk;
    t_out       r_q [4];
    t_out       n_q [4];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    logic       move;
    logic       pop;
    t_out       v_res [3];
    logic [1:0] v_n;

    assign move        = r_in_vld && (r_cnt <= 3'd1);
    assign pop         = (r_cnt != 3'd0) && i_out_ready;
    assign o_in_ready  = !r_in_vld || (r_cnt <= 3'd1);
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_q[0];

    // result list and next state for the registered byte
    always_comb begin
        logic [7:0] v_byte [3];
        logic       v_pres [3];
        logic       v_last;
        logic       v_bad;
        t_chk       v_chk;
        v_last = r_in.last_byte;
        v_chk  = r_chk;
        v_n    = 2'd0;
        n_bom  = r_bom;
        for (int k = 0; k < 3; k++) begin
            v_byte[k] = 8'h00;
            v_pres[k] = 1'b1;
        end
        unique case (r_bom)
            BOM_START: begin
                if (!r_keep_bom && r_in.data_byte == BYTE_EF) begin
                    n_bom = BOM_EF;
                end else begin
                    n_bom     = BOM_PAST;
                    v_byte[0] = r_in.data_byte;
                    v_n       = 2'd1;
                end
            end
            BOM_EF: begin
                if (r_in.data_byte == BYTE_BB) begin
                    n_bom = BOM_EFBB;
                end else begin
                    n_bom     = BOM_PAST;
                    v_byte[0] = BYTE_EF;
                    v_byte[1] = r_in.data_byte;
                    v_n       = 2'd2;
                end
            end
            BOM_EFBB: begin
                n_bom = BOM_PAST;
                if (r_in.data_byte != BYTE_BF) begin
                    v_byte[0] = BYTE_EF;
                    v_byte[1] = BYTE_BB;
                    v_byte[2] = r_in.data_byte;
                    v_n       = 2'd3;
                end
            end
            default: begin
                v_byte[0] = r_in.data_byte;
                v_n       = 2'd1;
            end
        endcase
        // release held bytes at buffer end, only reached with nothing emitted
        if (v_last) begin
            if (n_bom == BOM_EF) begin
                v_byte[0] = BYTE_EF;
                v_n       = 2'd1;
            end else if (n_bom == BOM_EFBB) begin
                v_byte[0] = BYTE_EF;
                v_byte[1] = BYTE_BB;
                v_n       = 2'd2;
            end
            if (v_n == 2'd0) begin
                v_pres[0] = 1'b0;
                v_n       = 2'd1;
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < v_n && v_pres[k]) v_chk = check_byte(v_chk, v_byte[k]);
        end
        v_bad = v_chk.err || (v_chk.cont_left != 2'd0);
        for (int k = 0; k < 3; k++) begin
            v_res[k].out_byte     = v_byte[k];
            v_res[k].out_present  = v_pres[k];
            v_res[k].run_last     = (2'(k) == v_n - 2'd1);
            v_res[k].buffer_done  = v_last && (2'(k) == v_n - 2'd1);
            v_res[k].invalid_text = v_last && (2'(k) == v_n - 2'd1) && r_fatal_mode && v_bad;
        end
        if (v_last) begin
            n_bom           = BOM_START;
            n_chk.cont_left = 2'd0;
            n_chk.rule      = RULE_ANY;
            n_chk.err       = 1'b0;
        end else begin
            n_chk = v_chk;
        end
    end

    // result queue: pop from the head, append behind what remains
    always_comb begin
        logic [2:0] v_pos;
        v_pos = 3'd0;
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            for (int k = 0; k < 3; k++) n_q[k] = r_q[k + 1];
            n_cnt = r_cnt - 3'd1;
        end
        if (move) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < v_n) begin
                    v_pos             = n_cnt + 3'(k);
                    n_q[v_pos[1:0]]   = v_res[k];
                end
            end
            n_cnt = n_cnt + {1'b0, v_n};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fatal_mode <= 1'b0;
            r_keep_bom   <= 1'b0;
            r_in_vld     <= 1'b0;
            r_bom        <= BOM_START;
            r_chk        <= '{cont_left: 2'd0, rule: RULE_ANY, err: 1'b0};
            r_cnt        <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FATAL_MODE: r_fatal_mode <= i_cfg_wdata;
                    CFG_KEEP_BOM:   r_keep_bom   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_bom <= n_bom;
                r_chk <= n_chk;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in <= i_in_data;
        r_q <= n_q;
    end

endmodule

/* sv/u8vbs_chk.sv */
`include "assert_macros.svh"

module u8vbs_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  u8vbs_pkg::t_out i_out_data
);
    import u8vbs_pkg::*;

    logic v_done_word;
    logic v_err_word;
    logic v_stat_word;
    logic v_stat_ok;

    assign v_done_word = i_out_valid && i_out_data.buffer_done;
    assign v_err_word  = i_out_valid && i_out_data.invalid_text;
    assign v_stat_word = i_out_valid && !i_out_data.out_present;
    assign v_stat_ok   = i_out_data.buffer_done && (i_out_data.out_byte == 8'h00);

    // a stalled word stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // the buffer's final word also closes its byte's run
    `ASSERT_ALWAYS(a_done_run, i_clk, i_rst_n, !v_done_word || i_out_data.run_last)

    // error flag only on the buffer's final word
    `ASSERT_ALWAYS(a_err_done, i_clk, i_rst_n, !v_err_word || i_out_data.buffer_done)

    // status-only word carries zero and ends the buffer
    `ASSERT_ALWAYS(a_status, i_clk, i_rst_n, !v_stat_word || v_stat_ok)

endmodule

bind utf8_validate_bom_strip u8vbs_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

/* tb/utf8_validate_bom_strip_tb.sv */
module utf8_validate_bom_strip_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8vbs_pkg::*;

    typedef logic [7:0] byte_q [$];

    // expected text words of the filter, worked out per accepted byte
    class text_result_board;
        bit          fatal_on;
        bit          keep_mark;
        t_bom        mark_state;
        logic [1:0]  conts_due;
        t_rule       next_range;
        bit          bad_seen;
        t_out        step_words[$];
        t_out        pending_words[$];
        int unsigned mismatches;
        int unsigned words_checked;

        function new();
            fatal_on      = 1'b0;
            keep_mark     = 1'b0;
            mismatches    = 0;
            words_checked = 0;
            restart();
        endfunction

        function void restart();
            mark_state = BOM_START;
            conts_due  = 2'd0;
            next_range = RULE_ANY;
            bad_seen   = 1'b0;
        endfunction

        function void set_regs(bit fm, bit kb);
            fatal_on  = fm;
            keep_mark = kb;
        endfunction

        // running well-formedness check over the bytes that pass
        function void scan_char(logic [7:0] b);
            bit ok;
            if (conts_due != 2'd0) begin
                ok = (b & CONT_MASK) == CONT_TAG;
                case (next_range)
                    RULE_A0_BF: ok = ok && (b >= CONT_A0);
                    RULE_80_9F: ok = ok && (b < CONT_A0);
                    RULE_90_BF: ok = ok && (b >= CONT_90);
                    RULE_80_8F: ok = ok && (b <= CONT_8F);
                    default: ;
                endcase
                next_range = RULE_ANY;
                if (ok) begin
                    conts_due = conts_due - 2'd1;
                    return;
                end
                // broken sequence, byte is taken again as a lead
                bad_seen  = 1'b1;
                conts_due = 2'd0;
            end
            if (b < ASCII_LIM) begin
            end else if (b < LEAD_2B) begin
                bad_seen = 1'b1;
            end else if (b < LEAD_3B) begin
                conts_due = 2'd1;
            end else if (b < LEAD_4B) begin
                conts_due = 2'd2;
                if (b == LEAD_3B) next_range = RULE_A0_BF;
                else if (b == LEAD_SURR) next_range = RULE_80_9F;
            end else if (b <= LEAD_MAX) begin
                conts_due = 2'd3;
                if (b == LEAD_4B) next_range = RULE_90_BF;
                else if (b == LEAD_MAX) next_range = RULE_80_8F;
            end else begin
                bad_seen = 1'b1;
            end
        endfunction

        function void pass_char(logic [7:0] b);
            t_out w;
            w             = '0;
            w.out_byte    = b;
            w.out_present = 1'b1;
            step_words.push_back(w);
            scan_char(b);
        endfunction

        function void note_byte(t_in w);
            t_out tail;
            int   last_idx;
            step_words.delete();
            case (mark_state)
                BOM_START: begin
                    if (!keep_mark && w.data_byte == BYTE_EF) begin
                        mark_state = BOM_EF;
                    end else begin
                        mark_state = BOM_PAST;
                        pass_char(w.data_byte);
                    end
                end
                BOM_EF: begin
                    if (w.data_byte == BYTE_BB) begin
                        mark_state = BOM_EFBB;
                    end else begin
                        mark_state = BOM_PAST;
                        pass_char(BYTE_EF);
                        pass_char(w.data_byte);
                    end
                end
                BOM_EFBB: begin
                    mark_state = BOM_PAST;
                    if (w.data_byte != BYTE_BF) begin
                        pass_char(BYTE_EF);
                        pass_char(BYTE_BB);
                        pass_char(w.data_byte);
                    end
                end
                default: pass_char(w.data_byte);
            endcase
            if (w.last_byte) begin
                // held mark bytes go out at buffer end
                if (mark_state == BOM_EF) begin
                    pass_char(BYTE_EF);
                end else if (mark_state == BOM_EFBB) begin
                    pass_char(BYTE_EF);
                    pass_char(BYTE_BB);
                end
                if (step_words.size() == 0) begin
                    tail = '0;
                    step_words.push_back(tail);
                end
                if (conts_due != 2'd0) bad_seen = 1'b1;
                last_idx = step_words.size() - 1;
                tail = step_words[last_idx];
                tail.buffer_done  = 1'b1;
                tail.invalid_text = fatal_on && bad_seen;
                step_words[last_idx] = tail;
                restart();
            end
            if (step_words.size() > 0) begin
                last_idx = step_words.size() - 1;
                tail = step_words[last_idx];
                tail.run_last = 1'b1;
                step_words[last_idx] = tail;
            end
            foreach (step_words[i]) pending_words.push_back(step_words[i]);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 20) $display("word %0d: %s", words_checked, what);
        endtask

        task check_word(t_out got);
            t_out want;
            words_checked++;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word %02h", got.out_byte));
            end else begin
                want = pending_words.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte %02h, wanted %02h", got.out_byte, want.out_byte));
                if (got.out_present !== want.out_present)
                    report($sformatf("out_present %b, wanted %b",
                                     got.out_present, want.out_present));
                if (got.run_last !== want.run_last)
                    report($sformatf("run_last %b, wanted %b", got.run_last, want.run_last));
                if (got.buffer_done !== want.buffer_done)
                    report($sformatf("buffer_done %b, wanted %b",
                                     got.buffer_done, want.buffer_done));
                if (got.invalid_text !== want.invalid_text)
                    report($sformatf("invalid_text %b, wanted %b",
                                     got.invalid_text, want.invalid_text));
            end
        endtask
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_idx   = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    text_result_board board = new();

    bit          no_idle   = 1'b0;
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned bytes_sent   = 0;
    int unsigned buffers_sent = 0;
    int unsigned settings_run = 0;

    utf8_validate_bom_strip DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // receiver: checks accepted words, stalls at random or for a long hold
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_word(o_out_data);
        if (hold_seen != hold_reqs) begin
            hold_seen   <= hold_reqs;
            hold_left   <= 80;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 12);
        end
    end

    task send_byte(t_in w);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 12) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_byte(w);
        bytes_sent++;
    endtask

    task send_buffer(byte_q q, bit close);
        t_in w;
        foreach (q[i]) begin
            w.data_byte = q[i];
            w.last_byte = close && (i == q.size() - 1);
            send_byte(w);
        end
        if (close) buffers_sent++;
    endtask

    // wait for every expected word, then wait on for bytes still held
    task drain();
        i_in_valid <= 1'b0;
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task write_regs(bit fm, bit kb);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_FATAL_MODE;
        i_cfg_wdata <= fm;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_KEEP_BOM;
        i_cfg_wdata <= kb;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_regs(fm, kb);
        settings_run++;
    endtask

    function automatic logic [20:0] pick_point(int len);
        logic [20:0] lo;
        logic [20:0] hi;
        int          pick;
        case (len)
            1:       begin lo = 21'h0;     hi = 21'h7F;     end
            2:       begin lo = 21'h80;    hi = 21'h7FF;    end
            3:       begin lo = 21'h800;   hi = 21'hFFFF;   end
            default: begin lo = 21'h10000; hi = 21'h10FFFF; end
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0) return lo;
        if (pick == 1) return hi;
        if (len == 3 && pick == 2) return 21'hD7FF;
        if (len == 3 && pick == 3) return 21'hE000;
        return 21'($urandom_range(lo, hi));
    endfunction

    // mostly well-formed text with random content, some noise and broken forms
    function automatic void make_text(output byte_q q);
        int          pick;
        int          n_chars;
        int          len;
        logic [20:0] cp;
        q.delete();
        pick = $urandom_range(0, 9);
        if (pick < 2) q = {BYTE_EF, BYTE_BB, BYTE_BF};
        else if (pick == 2) q = {BYTE_EF};
        else if (pick == 3) q = {BYTE_EF, BYTE_BB};
        n_chars = $urandom_range(0, 5);
        repeat (n_chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                q.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 18) begin
                case ($urandom_range(0, 4))
                    0:       q.push_back(LEAD_3B);
                    1:       q.push_back(LEAD_SURR);
                    2:       q.push_back(LEAD_4B);
                    3:       q.push_back(LEAD_MAX);
                    default: q.push_back(8'($urandom_range(8'hC2, 8'hF4)));
                endcase
                if ($urandom_range(0, 1)) q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else q.push_back(8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(1, 4);
                cp  = pick_point(len);
                case (len)
                    1: q.push_back({1'b0, cp[6:0]});
                    2: begin
                        q.push_back({3'b110, cp[10:6]});
                        q.push_back({2'b10, cp[5:0]});
                    end
                    3: begin
                        q.push_back({4'b1110, cp[15:12]});
                        q.push_back({2'b10, cp[11:6]});
                        q.push_back({2'b10, cp[5:0]});
                    end
                    default: begin
                        q.push_back({5'b11110, cp[20:18]});
                        q.push_back({2'b10, cp[17:12]});
                        q.push_back({2'b10, cp[11:6]});
                        q.push_back({2'b10, cp[5:0]});
                    end
                endcase
            end
        end
        if (q.size() == 0) q.push_back(8'($urandom_range(0, 255)));
    endfunction

    initial begin
        byte_q       dq;
        int          p;
        int          phase_bytes;
        int          nbuf;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed buffers
        write_regs(1'b1, 1'b0);
        dq = {BYTE_EF, BYTE_BB, BYTE_BF, 8'h41};  send_buffer(dq, 1'b1);
        dq = {BYTE_EF, BYTE_BB, BYTE_BF};         send_buffer(dq, 1'b1);
        dq = {BYTE_EF};                           send_buffer(dq, 1'b1);
        dq = {BYTE_EF, BYTE_BB, 8'h00};           send_buffer(dq, 1'b1);
        dq = {LEAD_3B, 8'h80, 8'hFF};             send_buffer(dq, 1'b1);
        dq = {LEAD_SURR, CONT_A0};                send_buffer(dq, 1'b1);
        dq = {LEAD_MAX, CONT_90, 8'h80, 8'h80};   send_buffer(dq, 1'b1);
        dq = {LEAD_2B, 8'h41};                    send_buffer(dq, 1'b1);
        drain();
        write_regs(1'b1, 1'b1);
        dq = {BYTE_EF, BYTE_BB, BYTE_BF};         send_buffer(dq, 1'b1);
        drain();

        // random phases over all register settings
        for (p = 0; p < 8; p++) begin
            write_regs(p[0], p[1]);
            no_idle     <= (p == 2);
            phase_bytes = 0;
            nbuf        = 0;
            if (p == 3) hold_reqs <= hold_reqs + 1;
            while (phase_bytes < 45) begin
                make_text(dq);
                send_buffer(dq, 1'b1);
                phase_bytes += dq.size();
                nbuf++;
                if (p == 5 && nbuf == 3) drain();
            end
            // leave a buffer open across the register change
            if (p == 4 || p == 6) begin
                make_text(dq);
                send_buffer(dq, 1'b0);
            end
            drain();
        end
        no_idle <= 1'b0;
        dq = {8'h41};
        send_buffer(dq, 1'b1);
        drain();

        $display("covered %0d buffers, %0d bytes and %0d result words",
                 buffers_sent, bytes_sent, board.words_checked);
        $display("over %0d register settings, with a long output hold and input pauses",
                 settings_run);
        if (board.mismatches == 0 && board.pending_words.size() == 0) begin
            $display("utf8_validate_bom_strip: match");
        end else begin
            $display("utf8_validate_bom_strip: mismatch");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("timed out with %0d words still expected", board.pending_words.size());
        $display("utf8_validate_bom_strip: mismatch");
        $finish;
    end

endmodule
